// ===== hdl/lambertian_photon_hit_counter_macros.svh =====
// Assertion macros for the photon hit counter
`ifndef LAMBERTIAN_PHOTON_HIT_COUNTER_MACROS_SVH
`define LAMBERTIAN_PHOTON_HIT_COUNTER_MACROS_SVH
`ifndef ASSERT_OFF
`define LPHC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LPHC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPHC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LPHC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/lphc_pkg.sv =====
// Shared types, constants and tables of the photon hit counter
`timescale 1ns / 1ps
`default_nettype none
package lphc_pkg;
  localparam int FRAC_BITS       = 24;
  localparam int U_W             = 24;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int OUT_CNT_W       = 32;
  localparam int DIST_W          = 32;
  localparam int WHW_W           = 24;
  localparam int RAD_W           = 28;
  localparam int CFG_ADDR_W      = 4;
  localparam int CFG_DATA_W      = 32;

  localparam logic [1:0] REG_DISTANCE = 2'd0;
  localparam logic [1:0] REG_WINDOW   = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;

  localparam logic [DIST_W-1:0] DISTANCE_RST = 32'd838860800;
  localparam logic [WHW_W-1:0]  WINDOW_RST   = 24'd5033;
  localparam logic [RAD_W-1:0]  RADIUS_RST   = 28'd16777216;

  localparam int SQ_W     = 50;
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int DIV_Q_W  = 48;
  localparam int DEN_W    = 25;
  localparam int REM_W    = 28;
  localparam int STEP_W   = 6;

  localparam int TN_W   = 36;
  localparam int TN_LO  = 18;
  localparam int PROD_W = DIST_W + TN_W;
  localparam int DISP_W = 33;
  localparam int ACC_W  = 36;
  localparam logic [DISP_W-1:0] DISP_CAP = '1;
  localparam logic [SQ_W-1:0] ONE_2F = 50'h1_0000_0000_0000;

  localparam int Q_W = 30;
  localparam logic [Q_W:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [Q_W:0] HALF_PI_Q30 = 31'd1686629713;
  localparam int TRIG_W = 32;
  localparam logic [3:0] SIN_LAST = 4'd3;
  localparam logic [3:0] COS_FIRST = 4'd4;
  localparam logic [3:0] COS_LAST = 4'd8;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic [U_W-1:0] u_radial;
    logic [U_W-1:0] u_polar;
    logic [U_W-1:0] u_tilt;
    logic           tilt_sign;
    logic [U_W-1:0] u_azimuth;
    logic           miss;
    logic           tilt_zero;
  } lphc_item_t;

  typedef struct packed {
    logic             start;
    logic             is_div;
    logic [SQ_W-1:0]  num;
    logic [DEN_W-1:0] den;
  } lphc_sqdiv_req_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } lphc_trig_t;

  // reciprocal multipliers for the Horner divisors 72 42 20 6 90 56 30 12 2
  function automatic logic [Q_W:0] recip_mul(input logic [3:0] k);
    logic [Q_W:0] m;
    unique case (k)
      4'd0: m = 31'd1908874354;
      4'd1: m = 31'd1636178018;
      4'd2: m = 31'd1717986919;
      4'd3: m = 31'd1431655766;
      4'd4: m = 31'd1527099484;
      4'd5: m = 31'd1227133514;
      4'd6: m = 31'd1145324613;
      4'd7: m = 31'd1431655766;
      default: m = 31'd1073741824;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] recip_shift(input logic [3:0] k);
    logic [5:0] s;
    unique case (k)
      4'd0: s = 6'd37;
      4'd1: s = 6'd36;
      4'd2: s = 6'd35;
      4'd3: s = 6'd33;
      4'd4: s = 6'd37;
      4'd5: s = 6'd36;
      4'd6: s = 6'd35;
      4'd7: s = 6'd34;
      default: s = 6'd31;
    endcase
    return s;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/lphc_front.sv =====
// Input stage: classify photon requests and queue them for the back end
`timescale 1ns / 1ps
`default_nettype none
module lphc_front (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       push,
  output logic                      full,
  input  wire  [lphc_pkg::U_W-1:0]  in_u_radial,
  input  wire  [lphc_pkg::U_W-1:0]  in_u_polar,
  input  wire  [lphc_pkg::U_W-1:0]  in_u_tilt,
  input  wire                       in_tilt_sign,
  input  wire  [lphc_pkg::U_W-1:0]  in_u_azimuth,
  output lphc_pkg::lphc_item_t      q_head,
  output logic                      q_vld,
  input  wire                       q_pop
);
  import lphc_pkg::*;

  lphc_item_t ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en, rd_en;
  lphc_item_t item;

  assign full   = (cnt_r == 2'd2);
  assign q_vld  = (cnt_r != 2'd0);
  assign q_head = ent_r[rd_ptr_r];
  assign wr_en  = push && !full;
  assign rd_en  = q_pop && q_vld;

  always_comb begin
    item.u_radial  = in_u_radial;
    item.u_polar   = in_u_polar;
    item.u_tilt    = in_u_tilt;
    item.tilt_sign = in_tilt_sign;
    item.u_azimuth = in_u_azimuth;
    item.miss      = ({1'b0, in_u_tilt} >= (U_W+1)'(64'd1 << FRAC_BITS));
    item.tilt_zero = (in_u_tilt == '0);
  end

  always_comb begin
    wr_ptr_nxt = wr_en ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd_en ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r[wr_ptr_r] <= item;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lphc_sqdiv.sv =====
// Shared iterative unit: integer square root or restoring division
`timescale 1ns / 1ps
`default_nettype none
module lphc_sqdiv (
  input  wire                            clk,
  input  wire                            rst_n,
  input  lphc_pkg::lphc_sqdiv_req_t      req,
  output logic                           busy,
  output logic [lphc_pkg::DIV_Q_W-1:0]   res
);
  import lphc_pkg::*;

  logic              busy_r;
  logic [STEP_W-1:0] cnt_r;
  logic              mode_r;
  logic [SQ_W-1:0]   src_r;
  logic [DIV_Q_W-1:0] acc_r;
  logic [REM_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [REM_W-1:0]  rem_sq, trial, rem_dv, den_x;

  assign busy = busy_r;
  assign res  = acc_r;

  always_comb begin
    rem_sq = {rem_r[REM_W-3:0], src_r[SQ_W-1 -: 2]};
    trial  = {1'b0, acc_r[DEN_W-1:0], 2'b01};
    rem_dv = {rem_r[REM_W-2:0], src_r[SQ_W-1]};
    den_x  = REM_W'(den_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.is_div ? STEP_W'(DIV_Q_W) : STEP_W'(SQ_STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode_r <= req.is_div;
      src_r  <= req.num;
      den_r  <= req.den;
      acc_r  <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      if (mode_r) begin
        src_r <= src_r << 1;
        if (rem_dv >= den_x) begin
          rem_r <= rem_dv - den_x;
          acc_r <= {acc_r[DIV_Q_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_dv;
          acc_r <= {acc_r[DIV_Q_W-2:0], 1'b0};
        end
      end else begin
        src_r <= src_r << 2;
        if (rem_sq >= trial) begin
          rem_r <= rem_sq - trial;
          acc_r <= {acc_r[DIV_Q_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sq;
          acc_r <= {acc_r[DIV_Q_W-2:0], 1'b0};
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lphc_sincos.sv =====
// Sequenced cosine and sine of a 32-bit phase, one shared multiplier
`timescale 1ns / 1ps
`default_nettype none
module lphc_sincos (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire  [31:0]          phase,
  output logic                 busy,
  output lphc_pkg::lphc_trig_t trig
);
  import lphc_pkg::*;

  localparam logic [2:0] SC_IDLE = 3'd0;
  localparam logic [2:0] SC_X    = 3'd1;
  localparam logic [2:0] SC_X2   = 3'd2;
  localparam logic [2:0] SC_MV   = 3'd3;
  localparam logic [2:0] SC_DV   = 3'd4;
  localparam logic [2:0] SC_SFIN = 3'd5;
  localparam logic [2:0] SC_OUT  = 3'd6;

  logic [2:0]     state_r, state_nxt;
  logic [3:0]     k_r, k_nxt;
  logic [1:0]     quad_r;
  logic           neg_r;
  logic [Q_W-1:0] m_r, x_r, x2_r, v_r, sm_r;
  logic [Q_W:0]   t_r;
  lphc_trig_t     trig_r;

  logic [31:0]    pr;
  logic [Q_W-1:0] low, m_in;
  logic [Q_W:0]   mul_a, mul_b;
  logic [2*Q_W+1:0] prod, prod_sh;
  logic signed [TRIG_W-1:0] s_val, c_val;

  assign busy = (state_r != SC_IDLE);
  assign trig = trig_r;

  always_comb begin
    pr   = phase + 32'h2000_0000;
    low  = pr[Q_W-1:0];
    m_in = low[Q_W-1] ? (low - 30'h2000_0000) : (30'h2000_0000 - low);
  end

  always_comb begin
    mul_a = {1'b0, x_r};
    mul_b = t_r;
    unique case (state_r)
      SC_X: begin
        mul_a = {1'b0, m_r};
        mul_b = HALF_PI_Q30;
      end
      SC_X2: begin
        mul_b = {1'b0, x_r};
      end
      SC_MV: begin
        mul_a = {1'b0, x2_r};
      end
      SC_DV: begin
        mul_a = {1'b0, v_r};
        mul_b = recip_mul(k_r);
      end
      default: begin
        mul_a = {1'b0, x_r};
        mul_b = t_r;
      end
    endcase
    prod    = mul_a * mul_b;
    prod_sh = prod >> recip_shift(k_r);
  end

  always_comb begin
    s_val = neg_r ? (TRIG_W'(0) - TRIG_W'(sm_r)) : TRIG_W'(sm_r);
    c_val = TRIG_W'(t_r);
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      SC_IDLE: begin
        if (start) begin
          state_nxt = SC_X;
          k_nxt     = 4'd0;
        end
      end
      SC_X:  state_nxt = SC_X2;
      SC_X2: state_nxt = SC_MV;
      SC_MV: state_nxt = SC_DV;
      SC_DV: begin
        k_nxt = k_r + 4'd1;
        if (k_r == SIN_LAST) begin
          state_nxt = SC_SFIN;
        end else if (k_r == COS_LAST) begin
          state_nxt = SC_OUT;
        end else begin
          state_nxt = SC_MV;
        end
      end
      SC_SFIN: state_nxt = SC_MV;
      SC_OUT:  state_nxt = SC_IDLE;
      default: state_nxt = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      k_r     <= 4'd0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      SC_IDLE: begin
        if (start) begin
          quad_r <= pr[31:30];
          neg_r  <= !low[Q_W-1];
          m_r    <= m_in;
          t_r    <= Q30_ONE;
        end
      end
      SC_X:    x_r  <= prod[2*Q_W-1:Q_W];
      SC_X2:   x2_r <= prod[2*Q_W-1:Q_W];
      SC_MV:   v_r  <= prod[2*Q_W-1:Q_W];
      SC_DV:   t_r  <= Q30_ONE - prod_sh[Q_W:0];
      SC_SFIN: begin
        sm_r <= prod[2*Q_W-1:Q_W];
        t_r  <= Q30_ONE;
      end
      SC_OUT: begin
        unique case (quad_r)
          QUAD_0: begin
            trig_r.cos_v <= c_val;
            trig_r.sin_v <= s_val;
          end
          QUAD_1: begin
            trig_r.cos_v <= -s_val;
            trig_r.sin_v <= c_val;
          end
          QUAD_2: begin
            trig_r.cos_v <= -c_val;
            trig_r.sin_v <= -s_val;
          end
          default: begin
            trig_r.cos_v <= s_val;
            trig_r.sin_v <= -c_val;
          end
        endcase
      end
      default: begin
        x_r <= x_r;
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/lphc_back.sv =====
// Back end: per-photon geometry sequencer, hit counters and result register
`timescale 1ns / 1ps
`default_nettype none
module lphc_back #(
  parameter int COUNT_WIDTH = lphc_pkg::COUNT_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  lphc_pkg::lphc_item_t             q_head,
  input  wire                              q_vld,
  output logic                             q_pop,
  input  wire  [lphc_pkg::DIST_W-1:0]      distance,
  input  wire  [lphc_pkg::WHW_W-1:0]       window_half_width,
  input  wire  [lphc_pkg::RAD_W-1:0]       reflector_radius,
  output logic                             empty,
  input  wire                              pop,
  output logic                             out_hit,
  output logic [lphc_pkg::OUT_CNT_W-1:0]   out_hits_so_far,
  output logic [lphc_pkg::OUT_CNT_W-1:0]   out_samples_so_far
);
  import lphc_pkg::*;

  localparam logic [4:0] BK_IDLE   = 5'd0;
  localparam logic [4:0] BK_SQ1_GO = 5'd1;
  localparam logic [4:0] BK_SQ1_W  = 5'd2;
  localparam logic [4:0] BK_R      = 5'd3;
  localparam logic [4:0] BK_USQ    = 5'd4;
  localparam logic [4:0] BK_SQ2_GO = 5'd5;
  localparam logic [4:0] BK_SQ2_W  = 5'd6;
  localparam logic [4:0] BK_DIV_GO = 5'd7;
  localparam logic [4:0] BK_DIV_W  = 5'd8;
  localparam logic [4:0] BK_P0     = 5'd9;
  localparam logic [4:0] BK_P1     = 5'd10;
  localparam logic [4:0] BK_SC1_GO = 5'd11;
  localparam logic [4:0] BK_SC1_W  = 5'd12;
  localparam logic [4:0] BK_SC2_GO = 5'd13;
  localparam logic [4:0] BK_SC2_W  = 5'd14;
  localparam logic [4:0] BK_MUL    = 5'd15;
  localparam logic [4:0] BK_CMP    = 5'd16;
  localparam logic [4:0] BK_DONE   = 5'd17;

  logic [4:0]       state_r, state_nxt;
  logic [1:0]       idx_r;
  lphc_item_t       item_r;
  logic [U_W-1:0]   rs_r;
  logic [RAD_W-1:0] r_r;
  logic [SQ_W-1:0]  rad_r;
  logic [DEN_W-1:0] d_r;
  logic [TN_W-1:0]  tn_r;
  logic [PROD_W-1:0] p_r;
  lphc_trig_t       pol_r, azi_r;
  logic signed [ACC_W-1:0] x_acc_r, y_acc_r;
  logic             hit_r;

  logic                   out_vld_r;
  logic                   out_hit_r;
  logic [COUNT_WIDTH-1:0] hits_r, hits_nxt;
  logic [COUNT_WIDTH-1:0] samples_r, samples_nxt;

  lphc_sqdiv_req_t    sd_req;
  logic               sd_busy;
  logic [DIV_Q_W-1:0] sd_res;
  logic               sc_start, sc_busy;
  logic [31:0]        sc_phase;
  lphc_trig_t         sc_trig;

  logic [DISP_W-1:0]  disp;
  logic [RAD_W+U_W-1:0] r_prod;
  logic [2*U_W-1:0]   usq;
  logic [DIST_W+TN_LO-1:0] p_lo, p_hi;
  logic [DISP_W-1:0]  mag;
  logic signed [TRIG_W-1:0] c_sel;
  logic               c_neg, t_neg;
  logic [Q_W:0]       c_mag;
  logic [DISP_W+Q_W:0] m_prod;
  logic [ACC_W-1:0]   term_mag;
  logic signed [ACC_W-1:0] term;
  logic [ACC_W-1:0]   x_abs, y_abs;
  logic               fin;

  lphc_sqdiv u_sqdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sd_req),
    .busy  (sd_busy),
    .res   (sd_res)
  );

  lphc_sincos u_sincos (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sc_start),
    .phase (sc_phase),
    .busy  (sc_busy),
    .trig  (sc_trig)
  );

  assign q_pop = (state_r == BK_IDLE) && q_vld;
  assign fin   = (state_r == BK_DONE) && (!out_vld_r || pop);

  always_comb begin
    sd_req.start  = (state_r == BK_SQ1_GO) || (state_r == BK_SQ2_GO) ||
                    (state_r == BK_DIV_GO);
    sd_req.is_div = (state_r == BK_DIV_GO);
    sd_req.den    = d_r;
    unique case (state_r)
      BK_SQ1_GO: sd_req.num = {2'b00, item_r.u_radial, FRAC_BITS'(0)};
      BK_DIV_GO: sd_req.num = {item_r.u_tilt, FRAC_BITS'(0), 2'b00};
      default:   sd_req.num = rad_r;
    endcase
  end

  // phase = u * 2^(32-F) + half turn
  always_comb begin
    sc_start = (state_r == BK_SC1_GO) || (state_r == BK_SC2_GO);
    if (state_r == BK_SC1_GO) begin
      sc_phase = {item_r.u_polar, (32-U_W)'(0)} + 32'h8000_0000;
    end else begin
      sc_phase = {item_r.u_azimuth, (32-U_W)'(0)} + 32'h8000_0000;
    end
  end

  always_comb begin
    disp   = (|p_r[PROD_W-1:DISP_W+FRAC_BITS]) ? DISP_CAP
                                               : p_r[DISP_W+FRAC_BITS-1:FRAC_BITS];
    r_prod = reflector_radius * rs_r;
    usq    = item_r.u_tilt * item_r.u_tilt;
    p_lo   = distance * tn_r[TN_LO-1:0];
    p_hi   = distance * tn_r[TN_W-1:TN_LO];
  end

  always_comb begin
    unique case (idx_r)
      2'd0: c_sel = azi_r.cos_v;
      2'd1: c_sel = pol_r.cos_v;
      2'd2: c_sel = azi_r.sin_v;
      default: c_sel = pol_r.sin_v;
    endcase
    mag      = idx_r[0] ? DISP_W'(r_r) : disp;
    c_neg    = c_sel[TRIG_W-1];
    c_mag    = c_neg ? Q_W'(1) + (Q_W+1)'(~c_sel) : c_sel[Q_W:0];
    t_neg    = c_neg ^ (item_r.tilt_sign && !idx_r[0]);
    m_prod   = mag * c_mag;
    term_mag = ACC_W'(m_prod >> Q_W);
    term     = t_neg ? -$signed(term_mag) : $signed(term_mag);
    x_abs    = x_acc_r[ACC_W-1] ? ACC_W'(-x_acc_r) : ACC_W'(x_acc_r);
    y_abs    = y_acc_r[ACC_W-1] ? ACC_W'(-y_acc_r) : ACC_W'(y_acc_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_vld) begin
          state_nxt = q_head.miss ? BK_DONE : BK_SQ1_GO;
        end
      end
      BK_SQ1_GO: state_nxt = BK_SQ1_W;
      BK_SQ1_W:  if (!sd_busy) state_nxt = BK_R;
      BK_R:      state_nxt = item_r.tilt_zero ? BK_P0 : BK_USQ;
      BK_USQ:    state_nxt = BK_SQ2_GO;
      BK_SQ2_GO: state_nxt = BK_SQ2_W;
      BK_SQ2_W:  if (!sd_busy) state_nxt = BK_DIV_GO;
      BK_DIV_GO: state_nxt = BK_DIV_W;
      BK_DIV_W:  if (!sd_busy) state_nxt = BK_P0;
      BK_P0:     state_nxt = BK_P1;
      BK_P1:     state_nxt = BK_SC1_GO;
      BK_SC1_GO: state_nxt = BK_SC1_W;
      BK_SC1_W:  if (!sc_busy) state_nxt = BK_SC2_GO;
      BK_SC2_GO: state_nxt = BK_SC2_W;
      BK_SC2_W:  if (!sc_busy) state_nxt = BK_MUL;
      BK_MUL:    if (idx_r == 2'd3) state_nxt = BK_CMP;
      BK_CMP:    state_nxt = BK_DONE;
      BK_DONE:   if (fin) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    hits_nxt    = hits_r;
    samples_nxt = samples_r;
    if (hit_r && hits_r != '1) begin
      hits_nxt = hits_r + 1'b1;
    end
    if (samples_r != '1) begin
      samples_nxt = samples_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      out_vld_r <= 1'b0;
      hits_r    <= '0;
      samples_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (fin) begin
        out_vld_r <= 1'b1;
        hits_r    <= hits_nxt;
        samples_r <= samples_nxt;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_hit_r <= hit_r;
    end
    unique case (state_r)
      BK_IDLE: begin
        item_r  <= q_head;
        hit_r   <= 1'b0;
        idx_r   <= 2'd0;
        tn_r    <= '0;
        x_acc_r <= '0;
        y_acc_r <= '0;
      end
      BK_SQ1_W: rs_r <= sd_res[U_W-1:0];
      BK_R:     r_r  <= r_prod[RAD_W+FRAC_BITS-1:FRAC_BITS];
      BK_USQ:   rad_r <= ONE_2F - SQ_W'(usq);
      BK_SQ2_W: d_r  <= sd_res[DEN_W-1:0];
      BK_DIV_W: tn_r <= sd_res[TN_W-1:0];
      BK_P0:    p_r  <= PROD_W'(p_lo);
      BK_P1:    p_r  <= p_r + (PROD_W'(p_hi) << TN_LO);
      BK_SC1_W: pol_r <= sc_trig;
      BK_SC2_W: azi_r <= sc_trig;
      BK_MUL: begin
        idx_r <= idx_r + 2'd1;
        if (idx_r[1]) begin
          y_acc_r <= y_acc_r + term;
        end else begin
          x_acc_r <= x_acc_r + term;
        end
      end
      BK_CMP: hit_r <= (x_abs <= ACC_W'(window_half_width)) &&
                       (y_abs <= ACC_W'(window_half_width));
      default: begin
        idx_r <= idx_r;
      end
    endcase
  end

  assign empty              = !out_vld_r;
  assign out_hit            = out_hit_r;
  assign out_hits_so_far    = OUT_CNT_W'(hits_r);
  assign out_samples_so_far = OUT_CNT_W'(samples_r);
endmodule
`default_nettype wire

// ===== hdl/lambertian_photon_hit_counter.sv =====
// Each accepted request runs through the back-end sequencer; a zero tilt draw skips the second
// square root and the divider, and a miss goes straight to its result. The back end takes one
// photon at a time: both square roots and the divider share the one iterative unit.
// A two-entry request queue and a result register decouple both sides; a result left
// waiting for pop holds the back end until it is taken.
// Reset: synchronous active-low rst_n clears the counters, queue and sequencers
// and loads the configuration registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "lambertian_photon_hit_counter_macros.svh"
module lambertian_photon_hit_counter #(
  parameter int COUNT_WIDTH = lphc_pkg::COUNT_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              push,
  output logic                             full,
  input  wire  [lphc_pkg::U_W-1:0]         in_u_radial,
  input  wire  [lphc_pkg::U_W-1:0]         in_u_polar,
  input  wire  [lphc_pkg::U_W-1:0]         in_u_tilt,
  input  wire                              in_tilt_sign,
  input  wire  [lphc_pkg::U_W-1:0]         in_u_azimuth,
  output logic                             empty,
  input  wire                              pop,
  output logic                             out_hit,
  output logic [lphc_pkg::OUT_CNT_W-1:0]   out_hits_so_far,
  output logic [lphc_pkg::OUT_CNT_W-1:0]   out_samples_so_far,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [lphc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire  [lphc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lphc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import lphc_pkg::*;

  logic [DIST_W-1:0] distance_r;
  logic [WHW_W-1:0]  window_r;
  logic [RAD_W-1:0]  radius_r;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  lphc_item_t q_head;
  logic       q_vld, q_pop;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      distance_r <= DISTANCE_RST;
      window_r   <= WINDOW_RST;
      radius_r   <= RADIUS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DISTANCE: distance_r <= pwdata[DIST_W-1:0];
        REG_WINDOW:   window_r   <= pwdata[WHW_W-1:0];
        REG_RADIUS:   radius_r   <= pwdata[RAD_W-1:0];
        default:      distance_r <= distance_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DISTANCE: prdata = CFG_DATA_W'(distance_r);
      REG_WINDOW:   prdata = CFG_DATA_W'(window_r);
      REG_RADIUS:   prdata = CFG_DATA_W'(radius_r);
      default:      prdata = '0;
    endcase
  end

  lphc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_u_radial  (in_u_radial),
    .in_u_polar   (in_u_polar),
    .in_u_tilt    (in_u_tilt),
    .in_tilt_sign (in_tilt_sign),
    .in_u_azimuth (in_u_azimuth),
    .q_head       (q_head),
    .q_vld        (q_vld),
    .q_pop        (q_pop)
  );

  lphc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_head             (q_head),
    .q_vld              (q_vld),
    .q_pop              (q_pop),
    .distance           (distance_r),
    .window_half_width  (window_r),
    .reflector_radius   (radius_r),
    .empty              (empty),
    .pop                (pop),
    .out_hit            (out_hit),
    .out_hits_so_far    (out_hits_so_far),
    .out_samples_so_far (out_samples_so_far)
  );

  `LPHC_ASSERT_IMP(a_full_has_head, clk, rst_n, full, q_vld, "queue full without a head request")
  `LPHC_ASSERT_NXT(a_push_queued, clk, rst_n, push && !full, q_vld, "accepted request not queued")
  `LPHC_ASSERT_IMP(a_hits_le_samples, clk, rst_n, !empty && (COUNT_WIDTH <= OUT_CNT_W), out_hits_so_far <= out_samples_so_far, "hit count exceeds sample count")
  `LPHC_ASSERT_IMP(a_hit_counted, clk, rst_n, !empty && out_hit && (COUNT_WIDTH <= OUT_CNT_W), out_hits_so_far != '0, "hit result with zero hit count")
endmodule
`default_nettype wire
